[hw/rtl/tbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg
// Types and fixed widths shared by the bilinear texture sampler.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int COORD_W     = 17;
  localparam int FRAC_W      = 16;
  localparam int IDX_W       = 14;
  localparam int RGB_W       = 24;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int NUM_TAP     = 4;
  localparam int RES_W       = 16;
  // signed distance, wide enough for extrapolation past 1.0 at the largest size
  localparam int DIST_W      = 29;
  localparam int STORE_DEPTH = 16384;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   texel_index;
    logic [RGB_W-1:0]   texel_rgb;
    logic [COORD_W-1:0] u_coord;
    logic [COORD_W-1:0] v_coord;
  } in_t;

  typedef struct packed {
    logic [RES_W-1:0] red_out;
    logic [RES_W-1:0] green_out;
    logic [RES_W-1:0] blue_out;
  } out_t;

endpackage

[hw/rtl/tbs_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_axis
// One axis: scale by DIM, pick clamped neighbours, form Q.16 distances.
// ----------------------------------------------------------------------------
module tbs_axis #(
  parameter int DIM = 128
) (
  input  logic                                clk,
  input  logic [tbs_pkg::COORD_W-1:0]         coord,
  output logic [$clog2(DIM)-1:0]              lo_o,
  output logic [$clog2(DIM)-1:0]              hi_o,
  output logic signed [tbs_pkg::DIST_W-1:0]   d_lo_o,
  output logic signed [tbs_pkg::DIST_W-1:0]   d_hi_o
);
  import tbs_pkg::*;

  localparam int DW = $clog2(DIM + 1);
  localparam int PW = COORD_W + DW;
  localparam int FW = PW - FRAC_W;
  localparam int IW = $clog2(DIM);
  localparam int EW = PW + 2;

  logic [PW-1:0]   pos_r, pos2_r;
  logic [FW-1:0]   fl;
  logic [FW:0]     ce;
  logic [FW:0]     fl_c, ce_c;
  logic [IW-1:0]   lo_nxt, hi_nxt, lo_r, hi_r;
  logic signed [EW-1:0] pos_s, lo_s, hi_s;

  always_comb begin
    fl   = pos_r[PW-1:FRAC_W];
    ce   = (FW+1)'(fl) + (FW+1)'(|pos_r[FRAC_W-1:0]);
    fl_c = ((FW+1)'(fl) > (FW+1)'(DIM - 1)) ? (FW+1)'(DIM - 1) : (FW+1)'(fl);
    ce_c = (ce > (FW+1)'(DIM - 1)) ? (FW+1)'(DIM - 1) : ce;
    lo_nxt = IW'(fl_c);
    hi_nxt = IW'(ce_c);
    if (fl_c == ce_c) begin
      if (fl_c == '0) begin
        hi_nxt = IW'(1);
      end else begin
        lo_nxt = IW'(ce_c - (FW+1)'(1));
      end
    end
  end

  always_comb begin
    pos_s = EW'(pos2_r);
    lo_s  = EW'({lo_r, {FRAC_W{1'b0}}});
    hi_s  = EW'({hi_r, {FRAC_W{1'b0}}});
  end

  always_ff @(posedge clk) begin
    pos_r  <= PW'(coord) * PW'(DIM);
    pos2_r <= pos_r;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    d_lo_o <= DIST_W'(pos_s - lo_s);
    d_hi_o <= DIST_W'(hi_s - pos_s);
  end

  assign lo_o = lo_r;
  assign hi_o = hi_r;

endmodule

[hw/rtl/tbs_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_store
// Texel memory, held as two copies with two read ports each.
// ----------------------------------------------------------------------------
module tbs_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tbs_pkg::IDX_W-1:0]  waddr,
  input  logic [tbs_pkg::RGB_W-1:0]  wdata,
  input  logic [tbs_pkg::IDX_W-1:0]  raddr [tbs_pkg::NUM_TAP],
  output logic [tbs_pkg::RGB_W-1:0]  rdata [tbs_pkg::NUM_TAP]
);
  import tbs_pkg::*;

  logic [RGB_W-1:0] mem_a [STORE_DEPTH];
  logic [RGB_W-1:0] mem_b [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wdata;
      mem_b[waddr] <= wdata;
    end
    rdata[0] <= mem_a[raddr[0]];
    rdata[1] <= mem_a[raddr[1]];
    rdata[2] <= mem_b[raddr[2]];
    rdata[3] <= mem_b[raddr[3]];
  end

endmodule

[hw/rtl/tbs_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_blend
// Area weights, per-channel weighted sum, scale by 1/255 and saturate.
// ----------------------------------------------------------------------------
module tbs_blend (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              valid_i,
  input  logic signed [tbs_pkg::DIST_W-1:0] dy0,
  input  logic signed [tbs_pkg::DIST_W-1:0] dy1,
  input  logic signed [tbs_pkg::DIST_W-1:0] dx0,
  input  logic signed [tbs_pkg::DIST_W-1:0] dx1,
  input  logic [tbs_pkg::RGB_W-1:0]         tx [tbs_pkg::NUM_TAP],
  output logic                              valid_o,
  output tbs_pkg::out_t                     data_o
);
  import tbs_pkg::*;

  localparam int W_W   = 2 * DIST_W;
  localparam int P_W   = W_W + CHAN_W + 1;
  localparam int S_W   = P_W + 2;
  localparam int T_W   = S_W - 1 - 24;
  localparam int Q_W   = T_W - 7;
  localparam int M_W   = 25;
  localparam logic [M_W-1:0] RECIP = M_W'(16843009);

  logic v4_r, v5_r, v6_r, v7_r, out_valid_r;
  logic signed [W_W-1:0] w_r   [NUM_TAP];
  logic signed [P_W-1:0] p_r   [NUM_CHAN][NUM_TAP];
  logic signed [S_W-1:0] s_r   [NUM_CHAN];
  logic [T_W-1:0]        t_r   [NUM_CHAN];
  logic [Q_W-1:0]        q_r   [NUM_CHAN];
  logic                  pos_r [NUM_CHAN];
  logic [RES_W-1:0]      res_nxt [NUM_CHAN];
  logic [RES_W-1:0]      res_r   [NUM_CHAN];
  logic [T_W-1:0]        rem;
  logic [Q_W-1:0]        qc;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      rem = t_r[c] - T_W'({q_r[c], 8'h00}) + T_W'(q_r[c]);
      qc  = (rem >= T_W'(255)) ? q_r[c] + Q_W'(1) : q_r[c];
      if (!pos_r[c]) begin
        res_nxt[c] = '0;
      end else if (qc > Q_W'(65535)) begin
        res_nxt[c] = '1;
      end else begin
        res_nxt[c] = RES_W'(qc);
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r[0] <= W_W'(dy1 * dx1);
    w_r[1] <= W_W'(dy1 * dx0);
    w_r[2] <= W_W'(dy0 * dx1);
    w_r[3] <= W_W'(dy0 * dx0);
    for (int c = 0; c < NUM_CHAN; c++) begin
      for (int k = 0; k < NUM_TAP; k++) begin
        p_r[c][k] <= P_W'($signed({1'b0, tx[k][RGB_W-1-CHAN_W*c -: CHAN_W]}) * w_r[k]);
      end
      s_r[c]   <= S_W'(p_r[c][0]) + S_W'(p_r[c][1]) + S_W'(p_r[c][2]) + S_W'(p_r[c][3]);
      pos_r[c] <= (s_r[c] > 0);
      t_r[c]   <= s_r[c][S_W-2:24];
      q_r[c]   <= Q_W'(((T_W+M_W)'(s_r[c][S_W-2:24]) * (T_W+M_W)'(RECIP)) >> 32);
      res_r[c] <= res_nxt[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v4_r        <= valid_i;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  assign valid_o          = out_valid_r;
  assign data_o.red_out   = res_r[0];
  assign data_o.green_out = res_r[1];
  assign data_o.blue_out  = res_r[2];

endmodule

[hw/rtl/texture_bilinear_sample.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_bilinear_sample
// Bilinear sampler over a square RGB texel store with texel write items.
//
//   channel  ports                      transfer when
//   input    start, busy, in_data       start high and busy low
//   result   out_valid, out_data        out_valid high, one cycle
//
// one item accepted every cycle; busy is always low
// a sample result is registered out on the result ports in order of transfer; a write gives none
// four texel reads per sample from two dual-read copies of the store
// reset clears valid bits only; store contents undefined until written
// ----------------------------------------------------------------------------
module texture_bilinear_sample #(
  parameter int DIM = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tbs_pkg::in_t   in_data,
  output logic           out_valid,
  output tbs_pkg::out_t  out_data
);
  import tbs_pkg::*;

  localparam int IW = $clog2(DIM);

  logic        v0_r, sv1_r, sv2_r, sv3_r, wr1_r, wr2_r, wr3_r;
  in_t         d0_r;
  logic [IDX_W-1:0] widx1_r, widx2_r, widx3_r;
  logic [RGB_W-1:0] wrgb1_r, wrgb2_r, wrgb3_r;
  logic [IW-1:0]    y0, y1, x0, x1;
  logic signed [DIST_W-1:0] dy0, dy1, dx0, dx1;
  logic [IDX_W-1:0] raddr_r [NUM_TAP];
  logic [RGB_W-1:0] tx [NUM_TAP];

  function automatic logic [IDX_W-1:0] flat(input logic [IW-1:0] r, input logic [IW-1:0] c);
    flat = IDX_W'(IDX_W'(r) * IDX_W'(DIM) + IDX_W'(c));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      sv1_r <= 1'b0;
      sv2_r <= 1'b0;
      sv3_r <= 1'b0;
      wr1_r <= 1'b0;
      wr2_r <= 1'b0;
      wr3_r <= 1'b0;
    end else begin
      v0_r  <= start && !busy;
      sv1_r <= v0_r && (d0_r.op == OP_SAMPLE);
      wr1_r <= v0_r && (d0_r.op == OP_WRITE);
      sv2_r <= sv1_r;
      sv3_r <= sv2_r;
      wr2_r <= wr1_r;
      wr3_r <= wr2_r;
    end
  end

  always_ff @(posedge clk) begin
    d0_r       <= in_data;
    widx1_r    <= d0_r.texel_index;
    wrgb1_r    <= d0_r.texel_rgb;
    widx2_r    <= widx1_r;
    wrgb2_r    <= wrgb1_r;
    widx3_r    <= widx2_r;
    wrgb3_r    <= wrgb2_r;
    raddr_r[0] <= flat(y0, x0);
    raddr_r[1] <= flat(y0, x1);
    raddr_r[2] <= flat(y1, x0);
    raddr_r[3] <= flat(y1, x1);
  end

  tbs_axis #(.DIM(DIM)) u_axis_u (
    .clk(clk), .coord(d0_r.u_coord), .lo_o(y0), .hi_o(y1), .d_lo_o(dy0), .d_hi_o(dy1)
  );

  tbs_axis #(.DIM(DIM)) u_axis_v (
    .clk(clk), .coord(d0_r.v_coord), .lo_o(x0), .hi_o(x1), .d_lo_o(dx0), .d_hi_o(dx1)
  );

  tbs_store u_store (
    .clk(clk), .we(wr3_r), .waddr(widx3_r), .wdata(wrgb3_r), .raddr(raddr_r), .rdata(tx)
  );

  tbs_blend u_blend (
    .clk(clk), .rst_n(rst_n), .valid_i(sv3_r),
    .dy0(dy0), .dy1(dy1), .dx0(dx0), .dx1(dx1), .tx(tx),
    .valid_o(out_valid), .data_o(out_data)
  );

  assign busy = 1'b0;

endmodule
